// ===== sv/bsp_pkg.sv =====
// Package for the bencode stream parser: event and error codes, parser
// phases and the result word type. No dependencies.
package bsp_pkg;

    localparam logic [3:0] EV_MAP   = 4'd0;
    localparam logic [3:0] EV_LIST  = 4'd1;
    localparam logic [3:0] EV_END   = 4'd2;
    localparam logic [3:0] EV_INT   = 4'd3;
    localparam logic [3:0] EV_KBYTE = 4'd4;
    localparam logic [3:0] EV_KEND  = 4'd5;
    localparam logic [3:0] EV_VBYTE = 4'd6;
    localparam logic [3:0] EV_VEND  = 4'd7;
    localparam logic [3:0] EV_NULL  = 4'd8;
    localparam logic [3:0] EV_ERR   = 4'd9;

    localparam logic [2:0] ER_BADLEN  = 3'd0;
    localparam logic [2:0] ER_NOCOLON = 3'd1;
    localparam logic [2:0] ER_NODIGIT = 3'd2;
    localparam logic [2:0] ER_NOEND   = 3'd3;
    localparam logic [2:0] ER_DEEP    = 3'd4;
    localparam logic [2:0] ER_LONG    = 3'd5;
    localparam logic [2:0] ER_OVF     = 3'd6;
    localparam logic [2:0] ER_TRUNC   = 3'd7;

    localparam logic [7:0] CH_D     = 8'h64;
    localparam logic [7:0] CH_L     = 8'h6C;
    localparam logic [7:0] CH_I     = 8'h69;
    localparam logic [7:0] CH_E     = 8'h65;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [31:0] MAX_LEN_RESET = 32'd1048576;

    // UTF-8 bounds on the second byte of a sequence
    localparam logic [2:0] UB_NONE = 3'd0;
    localparam logic [2:0] UB_E0   = 3'd1;
    localparam logic [2:0] UB_ED   = 3'd2;
    localparam logic [2:0] UB_F0   = 3'd3;
    localparam logic [2:0] UB_F4   = 3'd4;

    typedef enum logic [8:0] {
        PH_VALUE  = 9'b000000001,
        PH_ITEM   = 9'b000000010,
        PH_KEY    = 9'b000000100,
        PH_KLEN   = 9'b000001000,
        PH_VLEN   = 9'b000010000,
        PH_KBYTES = 9'b000100000,
        PH_VBYTES = 9'b001000000,
        PH_INT    = 9'b010000000,
        PH_ERROR  = 9'b100000000
    } phase_t;

    typedef struct packed {
        logic [3:0]  ev;
        logic [7:0]  data;
        logic [63:0] ival;
        logic        text;
        logic [2:0]  err;
        logic [6:0]  depth;
        logic        last;
    } result_t;

    function automatic result_t make_res(input logic [3:0] ev, input logic [7:0] data,
                                         input logic [63:0] ival, input logic text,
                                         input logic [2:0] err, input logic [6:0] depth);
        result_t r;
        r.ev    = ev;
        r.data  = data;
        r.ival  = ival;
        r.text  = text;
        r.err   = err;
        r.depth = depth;
        r.last  = 1'b0;
        return r;
    endfunction

endpackage

// ===== sv/bencode_stream_parser_core.sv =====
// Bencode stream parser, top level: byte in, token event words out.
// Depends on bsp_pkg and bsp_ram (container stack below the top entry).
// The first result word is on m_tdata in the cycle after the byte is taken.
// Throughput: one byte per cycle while m_tready is high and each byte yields at
// most one word; a byte yielding two or three words holds s_tready low until
// the three-entry result queue, draining one word per cycle, is at its last word.
// Reset (rst_n low, async): parser idle at top level, limit 1048576, queue
// empty; the stack RAM is not cleared, only written entries are ever read.
module bencode_stream_parser_core #(
    parameter int MAX_DEPTH = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration: max_string_length
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data,
    // input bytes
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tlast,   // stream_end
    // result words
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata,   // [7:0] data_byte, [71:8] integer_value,
                                   // [72] is_text, [75:73] error_code,
                                   // [82:76] nest_depth, [87:83] zero
    output logic [3:0]  m_tuser,   // [3:0] event_res
    output logic        m_tlast    // last
);
    import bsp_pkg::*;

    localparam int DW = $clog2(MAX_DEPTH + 1);
    localparam int AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int RD = 1 << AW;

    logic [31:0]   max_len_reg;
    phase_t        ph_reg, ph_n;
    logic [DW-1:0] depth_reg, depth_n;
    logic          top_reg, top_n;
    logic [31:0]   acc_reg, acc_n, rem_reg, rem_n;
    logic [63:0]   mag_reg, mag_n;
    logic          neg_reg, neg_n, dig_reg, dig_n;
    logic [1:0]    up_reg, up_n;
    logic [2:0]    usb_reg, usb_n;
    logic          uv_reg, uv_n;
    logic          byp_reg, byp_val_reg;

    result_t       q_reg [3];
    logic [1:0]    cnt_reg;

    logic          accept, pop_out;
    logic [7:0]    b;
    logic          is_dig;
    logic [3:0]    dval;
    logic [35:0]   lbase, lsum;
    logic          lover;
    logic [67:0]   isum, ilimit;
    logic          below;
    logic          push_we;
    logic          do_start, do_pop;
    logic [DW-1:0] rd_depth, rd_tmp;
    logic [AW-1:0] ram_raddr, ram_waddr;
    logic [DW-1:0] wr_tmp;
    logic          ram_rdata;
    result_t       r [3];
    logic [1:0]    n;
    logic [7:0]    lo, hi;

    assign cfg_ready = 1'b1;
    assign accept    = s_tvalid && s_tready;
    assign pop_out   = m_tvalid && m_tready;
    // take a byte when the queue is empty or its last word leaves now
    assign s_tready  = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && m_tready);

    assign b      = s_tdata;
    assign is_dig = (b >= CH_ZERO) && (b <= CH_NINE);
    assign dval   = 4'(b - CH_ZERO);

    // length times ten plus digit, by shift and add
    assign lbase = (ph_reg == PH_KLEN || ph_reg == PH_VLEN) ? {4'd0, acc_reg} : 36'd0;
    assign lsum  = {lbase[32:0], 3'b000} + {lbase[34:0], 1'b0} + {32'd0, dval};
    assign lover = lsum > {4'd0, max_len_reg};

    // magnitude limit: 2^63 for a negative integer, 2^63 - 1 otherwise
    assign isum   = {1'b0, mag_reg, 3'b000} + {3'b000, mag_reg, 1'b0} + {64'd0, dval};
    assign ilimit = neg_reg ? {4'd0, 1'b1, 63'd0} : {4'd0, 1'b0, {63{1'b1}}};

    // entry just below the top of stack; bypass a write that raced the read
    assign below = byp_reg ? byp_val_reg : ram_rdata;

    always_comb
    begin
        ph_n     = ph_reg;
        depth_n  = depth_reg;
        top_n    = top_reg;
        acc_n    = acc_reg;
        rem_n    = rem_reg;
        mag_n    = mag_reg;
        neg_n    = neg_reg;
        dig_n    = dig_reg;
        up_n     = up_reg;
        usb_n    = usb_reg;
        uv_n     = uv_reg;
        push_we  = 1'b0;
        do_start = 1'b0;
        do_pop   = 1'b0;
        lo       = 8'h80;
        hi       = 8'hBF;
        n        = 2'd0;
        for (int k = 0; k < 3; k++)
        begin
            r[k] = make_res(EV_MAP, 8'd0, 64'd0, 1'b0, 3'd0, 7'd0);
        end

        unique case (ph_reg)
            PH_VALUE:
                do_start = 1'b1;
            PH_ITEM:
                if (b == CH_E) do_pop = 1'b1;
                else           do_start = 1'b1;
            PH_KEY:
            begin
                if (b == CH_E)
                begin
                    do_pop = 1'b1;
                end
                else if (is_dig)
                begin
                    acc_n = lsum[31:0];
                    if (lover)
                    begin
                        r[n] = make_res(EV_ERR, 8'd0, 64'd0, 1'b0, ER_LONG, 7'(depth_reg));
                        n = n + 2'd1;
                        ph_n = PH_ERROR;
                    end
                    else
                    begin
                        ph_n = PH_KLEN;
                    end
                end
                else
                begin
                    r[n] = make_res(EV_ERR, 8'd0, 64'd0, 1'b0, ER_BADLEN, 7'(depth_reg));
                    n = n + 2'd1;
                    ph_n = PH_ERROR;
                end
            end
            PH_KLEN, PH_VLEN:
            begin
                if (is_dig)
                begin
                    if (lover)
                    begin
                        r[n] = make_res(EV_ERR, 8'd0, 64'd0, 1'b0, ER_LONG, 7'(depth_reg));
                        n = n + 2'd1;
                        ph_n = PH_ERROR;
                    end
                    else
                    begin
                        acc_n = lsum[31:0];
                    end
                end
                else if (b != CH_COLON)
                begin
                    r[n] = make_res(EV_ERR, 8'd0, 64'd0, 1'b0, ER_NOCOLON, 7'(depth_reg));
                    n = n + 2'd1;
                    ph_n = PH_ERROR;
                end
                else if (ph_reg == PH_KLEN)
                begin
                    rem_n = acc_reg;
                    if (acc_reg == 32'd0)
                    begin
                        r[n] = make_res(EV_KEND, 8'd0, 64'd0, 1'b0, 3'd0, 7'(depth_reg));
                        n = n + 2'd1;
                        ph_n = PH_VALUE;
                    end
                    else
                    begin
                        ph_n = PH_KBYTES;
                    end
                end
                else
                begin
                    rem_n = acc_reg;
                    up_n  = 2'd0;
                    usb_n = UB_NONE;
                    uv_n  = 1'b1;
                    if (acc_reg == 32'd0)
                    begin
                        r[n] = make_res(EV_NULL, 8'd0, 64'd0, 1'b0, 3'd0, 7'(depth_reg));
                        n = n + 2'd1;
                        r[n] = make_res(EV_VEND, 8'd0, 64'd0, 1'b1, 3'd0, 7'(depth_reg));
                        n = n + 2'd1;
                        ph_n = (depth_reg == '0) ? PH_VALUE : (top_reg ? PH_KEY : PH_ITEM);
                    end
                    else
                    begin
                        ph_n = PH_VBYTES;
                    end
                end
            end
            PH_KBYTES:
            begin
                r[n] = make_res(EV_KBYTE, b, 64'd0, 1'b0, 3'd0, 7'(depth_reg));
                n = n + 2'd1;
                rem_n = (rem_reg != 32'd0) ? rem_reg - 32'd1 : 32'd0;
                if (rem_n == 32'd0)
                begin
                    r[n] = make_res(EV_KEND, 8'd0, 64'd0, 1'b0, 3'd0, 7'(depth_reg));
                    n = n + 2'd1;
                    ph_n = PH_VALUE;
                end
            end
            PH_VBYTES:
            begin
                r[n] = make_res(EV_VBYTE, b, 64'd0, 1'b0, 3'd0, 7'(depth_reg));
                n = n + 2'd1;
                // advance the UTF-8 checker by one byte
                if (uv_reg)
                begin
                    if (up_reg == 2'd0)
                    begin
                        usb_n = UB_NONE;
                        if (b < 8'h80)
                        begin
                            up_n = 2'd0;
                        end
                        else if (b >= 8'hC2 && b <= 8'hDF)
                        begin
                            up_n = 2'd1;
                        end
                        else if (b >= 8'hE0 && b <= 8'hEF)
                        begin
                            up_n  = 2'd2;
                            usb_n = (b == 8'hE0) ? UB_E0 : (b == 8'hED) ? UB_ED : UB_NONE;
                        end
                        else if (b >= 8'hF0 && b <= 8'hF4)
                        begin
                            up_n  = 2'd3;
                            usb_n = (b == 8'hF0) ? UB_F0 : (b == 8'hF4) ? UB_F4 : UB_NONE;
                        end
                        else
                        begin
                            uv_n = 1'b0;
                        end
                    end
                    else
                    begin
                        case (usb_reg)
                            UB_E0:   lo = 8'hA0;
                            UB_ED:   hi = 8'h9F;
                            UB_F0:   lo = 8'h90;
                            UB_F4:   hi = 8'h8F;
                            default: ;
                        endcase
                        if (b < lo || b > hi)
                        begin
                            uv_n = 1'b0;
                        end
                        else
                        begin
                            up_n  = up_reg - 2'd1;
                            usb_n = UB_NONE;
                        end
                    end
                end
                rem_n = (rem_reg != 32'd0) ? rem_reg - 32'd1 : 32'd0;
                if (rem_n == 32'd0)
                begin
                    r[n] = make_res(EV_VEND, 8'd0, 64'd0, uv_n && (up_n == 2'd0), 3'd0,
                                    7'(depth_reg));
                    n = n + 2'd1;
                    ph_n = (depth_reg == '0) ? PH_VALUE : (top_reg ? PH_KEY : PH_ITEM);
                end
            end
            PH_INT:
            begin
                if (b == CH_MINUS && !dig_reg && !neg_reg)
                begin
                    neg_n = 1'b1;
                end
                else if (is_dig)
                begin
                    if (isum > ilimit)
                    begin
                        r[n] = make_res(EV_ERR, 8'd0, 64'd0, 1'b0, ER_OVF, 7'(depth_reg));
                        n = n + 2'd1;
                        ph_n = PH_ERROR;
                    end
                    else
                    begin
                        mag_n = isum[63:0];
                        dig_n = 1'b1;
                    end
                end
                else if (!dig_reg)
                begin
                    r[n] = make_res(EV_ERR, 8'd0, 64'd0, 1'b0, ER_NODIGIT, 7'(depth_reg));
                    n = n + 2'd1;
                    ph_n = PH_ERROR;
                end
                else if (b == CH_E)
                begin
                    r[n] = make_res(EV_INT, 8'd0, neg_reg ? (64'd0 - mag_reg) : mag_reg,
                                    1'b0, 3'd0, 7'(depth_reg));
                    n = n + 2'd1;
                    ph_n = (depth_reg == '0) ? PH_VALUE : (top_reg ? PH_KEY : PH_ITEM);
                end
                else
                begin
                    r[n] = make_res(EV_ERR, 8'd0, 64'd0, 1'b0, ER_NOEND, 7'(depth_reg));
                    n = n + 2'd1;
                    ph_n = PH_ERROR;
                end
            end
            PH_ERROR: ;
            default: ;
        endcase

        if (do_pop)
        begin
            depth_n = (depth_reg != '0) ? depth_reg - DW'(1) : '0;
            top_n   = below;
            r[n] = make_res(EV_END, 8'd0, 64'd0, 1'b0, 3'd0, 7'(depth_n));
            n = n + 2'd1;
            ph_n = (depth_n == '0) ? PH_VALUE : (below ? PH_KEY : PH_ITEM);
        end

        if (do_start)
        begin
            if (b == CH_D || b == CH_L)
            begin
                if (depth_reg >= DW'(MAX_DEPTH))
                begin
                    r[n] = make_res(EV_ERR, 8'd0, 64'd0, 1'b0, ER_DEEP, 7'(depth_reg));
                    n = n + 2'd1;
                    ph_n = PH_ERROR;
                end
                else
                begin
                    push_we = 1'b1;
                    depth_n = depth_reg + DW'(1);
                    top_n   = (b == CH_D);
                    r[n] = make_res((b == CH_D) ? EV_MAP : EV_LIST, 8'd0, 64'd0, 1'b0, 3'd0,
                                    7'(depth_n));
                    n = n + 2'd1;
                    ph_n = (b == CH_D) ? PH_KEY : PH_ITEM;
                end
            end
            else if (b == CH_I)
            begin
                mag_n = 64'd0;
                neg_n = 1'b0;
                dig_n = 1'b0;
                ph_n  = PH_INT;
            end
            else if (is_dig)
            begin
                acc_n = lsum[31:0];
                if (lover)
                begin
                    r[n] = make_res(EV_ERR, 8'd0, 64'd0, 1'b0, ER_LONG, 7'(depth_reg));
                    n = n + 2'd1;
                    ph_n = PH_ERROR;
                end
                else
                begin
                    ph_n = PH_VLEN;
                end
            end
            else
            begin
                r[n] = make_res(EV_ERR, 8'd0, 64'd0, 1'b0, ER_BADLEN, 7'(depth_reg));
                n = n + 2'd1;
                ph_n = PH_ERROR;
            end
        end

        // end of stream: flag an unfinished value, then drop all parse state
        if (s_tlast)
        begin
            if (ph_n != PH_ERROR && !(ph_n == PH_VALUE && depth_n == '0))
            begin
                r[n] = make_res(EV_ERR, 8'd0, 64'd0, 1'b0, ER_TRUNC, 7'(depth_n));
                n = n + 2'd1;
            end
            ph_n    = PH_VALUE;
            depth_n = '0;
            acc_n   = 32'd0;
            rem_n   = 32'd0;
            mag_n   = 64'd0;
            neg_n   = 1'b0;
            dig_n   = 1'b0;
            up_n    = 2'd0;
            usb_n   = UB_NONE;
            uv_n    = 1'b1;
        end

        if (n != 2'd0)
        begin
            r[n - 2'd1].last = 1'b1;
        end
    end

    // stack RAM holds every entry below the top; the top lives in top_reg
    assign wr_tmp    = depth_reg - DW'(1);
    assign ram_waddr = wr_tmp[AW-1:0];
    assign rd_depth  = accept ? depth_n : depth_reg;
    assign rd_tmp    = rd_depth - DW'(2);
    assign ram_raddr = rd_tmp[AW-1:0];

    bsp_ram #(
        .WIDTH (1),
        .DEPTH (RD)
    ) u_stack (
        .clk   (clk),
        .we    (accept && push_we && (depth_reg != '0)),
        .waddr (ram_waddr),
        .wdata (top_reg),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= MAX_LEN_RESET;
            ph_reg      <= PH_VALUE;
            depth_reg   <= '0;
            top_reg     <= 1'b0;
            acc_reg     <= 32'd0;
            rem_reg     <= 32'd0;
            mag_reg     <= 64'd0;
            neg_reg     <= 1'b0;
            dig_reg     <= 1'b0;
            up_reg      <= 2'd0;
            usb_reg     <= UB_NONE;
            uv_reg      <= 1'b1;
            byp_reg     <= 1'b0;
            byp_val_reg <= 1'b0;
            cnt_reg     <= 2'd0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                max_len_reg <= cfg_data;
            end
            if (accept)
            begin
                ph_reg      <= ph_n;
                depth_reg   <= depth_n;
                top_reg     <= top_n;
                acc_reg     <= acc_n;
                rem_reg     <= rem_n;
                mag_reg     <= mag_n;
                neg_reg     <= neg_n;
                dig_reg     <= dig_n;
                up_reg      <= up_n;
                usb_reg     <= usb_n;
                uv_reg      <= uv_n;
                byp_reg     <= push_we;
                byp_val_reg <= top_reg;
                cnt_reg     <= n;
            end
            else if (pop_out)
            begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

    // result queue: load all words of a byte at once, shift one out per word
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            q_reg[0] <= r[0];
            q_reg[1] <= r[1];
            q_reg[2] <= r[2];
        end
        else if (pop_out)
        begin
            q_reg[0] <= q_reg[1];
            q_reg[1] <= q_reg[2];
        end
    end

    assign m_tvalid = (cnt_reg != 2'd0);
    assign m_tuser  = q_reg[0].ev;
    assign m_tlast  = q_reg[0].last;
    assign m_tdata  = {5'd0, q_reg[0].depth, q_reg[0].err, q_reg[0].text,
                       q_reg[0].ival, q_reg[0].data};
endmodule

// ===== sv/bsp_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module bsp_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
